// ===== sv/segment_reorder_receiver_assert.svh =====
// ----------------------------------------------------------------------------
// Segment reorder receiver assertion macros
// Shared concurrent assertion forms used by the receiver RTL.
// ----------------------------------------------------------------------------
`ifndef SEGMENT_REORDER_RECEIVER_ASSERT_SVH
`define SEGMENT_REORDER_RECEIVER_ASSERT_SVH

// same-cycle implication
`define SRR_ASSERT_HOLDS(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define SRR_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== sv/srr_pkg.sv =====
// ----------------------------------------------------------------------------
// Segment reorder receiver package
// Types, codes and reset constants shared by the receiver modules.
// ----------------------------------------------------------------------------
package srr_pkg;

    localparam int WINDOW_SLOTS_DEFAULT = 16;

    localparam int CFG_INDEX_W = 1;
    localparam int CFG_DATA_W  = 32;

    localparam logic [7:0]  HEADER_BYTES_RESET     = 8'd16;
    localparam logic [31:0] INITIAL_SEQUENCE_RESET = 32'd1;

    localparam logic [CFG_INDEX_W-1:0] CFG_HEADER_BYTES     = 1'b0;
    localparam logic [CFG_INDEX_W-1:0] CFG_INITIAL_SEQUENCE = 1'b1;

    typedef enum logic [1:0] {
        STATUS_ACCEPTED  = 2'd0,
        STATUS_OLDER     = 2'd1,
        STATUS_DUPLICATE = 2'd2,
        STATUS_FULL      = 2'd3
    } status_t;

    typedef enum logic {
        KIND_DELIVER = 1'b0,
        KIND_ACK     = 1'b1
    } kind_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SEARCH,
        S_SHIFT,
        S_INSERT,
        S_DELIV_RD,
        S_DELIV_CHK,
        S_ACK
    } state_t;

    typedef struct packed {
        logic [31:0] seq_number;
        logic [15:0] payload_length;
        logic        fin_mark;
        logic [7:0]  buffer_tag;
    } segment_t;

    typedef struct packed {
        kind_t       kind;
        logic [7:0]  out_tag;
        logic [15:0] out_length;
        logic [31:0] ack_number;
        logic        fin_seen;
        status_t     status;
        logic        last;
    } result_t;

    typedef struct packed {
        logic        valid;
        result_t     result;
    } emit_t;

    typedef struct packed {
        logic [7:0]  header_bytes;
        logic        load_seq;
        logic [31:0] seq_value;
    } cfg_t;

endpackage

// ===== sv/srr_ram.sv =====
// ----------------------------------------------------------------------------
// Generic RAM
// One write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module srr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== sv/srr_core.sv =====
// ----------------------------------------------------------------------------
// Segment reorder receiver core
// Sequencer over the sorted segment store: search, shift, insert, deliver.
// ----------------------------------------------------------------------------
module srr_core #(
    parameter int WINDOW_SLOTS = srr_pkg::WINDOW_SLOTS_DEFAULT
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  srr_pkg::segment_t segment,
    input  srr_pkg::cfg_t     cfg,
    output logic              busy,
    output srr_pkg::emit_t    emit
);

`include "segment_reorder_receiver_assert.svh"

    localparam int AW = $clog2(WINDOW_SLOTS);
    localparam int CW = $clog2(WINDOW_SLOTS + 1);
    localparam int EW = $bits(srr_pkg::segment_t);
    localparam logic [AW:0]   N_W  = (AW+1)'(WINDOW_SLOTS);
    localparam logic [CW-1:0] N_CW = CW'(WINDOW_SLOTS);

    srr_pkg::state_t   state_reg, state_next;
    logic [AW-1:0]     head_reg, head_next;
    logic [CW-1:0]     count_reg, count_next;
    logic [CW-1:0]     pos_reg, pos_next;
    srr_pkg::segment_t seg_reg, seg_next;
    srr_pkg::status_t  status_reg, status_next;
    logic              fin_reg, fin_next;
    logic [31:0]       expect_reg, expect_next;
    logic [CW-1:0]     sh_idx_reg, sh_idx_next;
    logic              sh_more_reg, sh_more_next;
    logic              pend_reg, pend_next;
    logic [CW-1:0]     pend_idx_reg, pend_idx_next;

    logic              ram_we;
    logic [AW-1:0]     ram_waddr;
    logic [EW-1:0]     ram_wdata;
    logic [AW-1:0]     ram_raddr;
    logic [EW-1:0]     ram_rdata;
    srr_pkg::segment_t rd_entry;
    logic [31:0]       advanced;

    function automatic logic [AW-1:0] phys(input logic [AW-1:0] base,
                                           input logic [CW-1:0] k);
        logic [AW:0] s;
        s = {1'b0, base} + (AW+1)'(k);
        if (s >= N_W)
        begin
            s = s - N_W;
        end
        return s[AW-1:0];
    endfunction

    srr_ram #(
        .WIDTH (EW),
        .DEPTH (WINDOW_SLOTS)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign rd_entry = srr_pkg::segment_t'(ram_rdata);
    assign advanced = expect_reg + 32'(rd_entry.payload_length) + 32'(cfg.header_bytes);
    assign busy     = (state_reg != srr_pkg::S_IDLE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= srr_pkg::S_IDLE;
            head_reg    <= '0;
            count_reg   <= '0;
            expect_reg  <= srr_pkg::INITIAL_SEQUENCE_RESET;
            sh_more_reg <= 1'b0;
            pend_reg    <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            head_reg    <= head_next;
            count_reg   <= count_next;
            expect_reg  <= expect_next;
            sh_more_reg <= sh_more_next;
            pend_reg    <= pend_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pos_reg      <= pos_next;
        seg_reg      <= seg_next;
        status_reg   <= status_next;
        fin_reg      <= fin_next;
        sh_idx_reg   <= sh_idx_next;
        pend_idx_reg <= pend_idx_next;
    end

    always_comb
    begin
        state_next    = state_reg;
        head_next     = head_reg;
        count_next    = count_reg;
        pos_next      = pos_reg;
        seg_next      = seg_reg;
        status_next   = status_reg;
        fin_next      = fin_reg;
        expect_next   = expect_reg;
        sh_idx_next   = sh_idx_reg;
        sh_more_next  = sh_more_reg;
        pend_next     = pend_reg;
        pend_idx_next = pend_idx_reg;
        ram_we        = 1'b0;
        ram_waddr     = head_reg;
        ram_wdata     = ram_rdata;
        ram_raddr     = head_reg;
        emit          = '0;

        case (state_reg)
            srr_pkg::S_IDLE:
            begin
                if (start)
                begin
                    seg_next = segment;
                    pos_next = '0;
                    fin_next = 1'b0;
                    if (segment.seq_number < expect_reg)
                    begin
                        status_next = srr_pkg::STATUS_OLDER;
                        state_next  = srr_pkg::S_DELIV_RD;
                    end
                    else
                    begin
                        status_next = srr_pkg::STATUS_ACCEPTED;
                        state_next  = srr_pkg::S_SEARCH;
                    end
                end
            end

            srr_pkg::S_SEARCH:
            begin
                if (pos_reg < count_reg && rd_entry.seq_number < seg_reg.seq_number)
                begin
                    pos_next  = pos_reg + 1'b1;
                    ram_raddr = phys(head_reg, pos_reg + 1'b1);
                end
                else if (pos_reg < count_reg && rd_entry.seq_number == seg_reg.seq_number)
                begin
                    status_next = srr_pkg::STATUS_DUPLICATE;
                    state_next  = srr_pkg::S_DELIV_RD;
                end
                else if (count_reg == N_CW)
                begin
                    status_next = srr_pkg::STATUS_FULL;
                    state_next  = srr_pkg::S_DELIV_RD;
                end
                else if (pos_reg == count_reg)
                begin
                    state_next = srr_pkg::S_INSERT;
                end
                else
                begin
                    sh_idx_next  = count_reg - 1'b1;
                    sh_more_next = 1'b1;
                    pend_next    = 1'b0;
                    state_next   = srr_pkg::S_SHIFT;
                end
            end

            srr_pkg::S_SHIFT:
            begin
                // read entry j while writing the previous read one slot up
                if (pend_reg)
                begin
                    ram_we    = 1'b1;
                    ram_waddr = phys(head_reg, pend_idx_reg + 1'b1);
                    ram_wdata = ram_rdata;
                end
                if (sh_more_reg)
                begin
                    ram_raddr     = phys(head_reg, sh_idx_reg);
                    pend_next     = 1'b1;
                    pend_idx_next = sh_idx_reg;
                    if (sh_idx_reg == pos_reg)
                    begin
                        sh_more_next = 1'b0;
                    end
                    else
                    begin
                        sh_idx_next = sh_idx_reg - 1'b1;
                    end
                end
                else
                begin
                    pend_next  = 1'b0;
                    state_next = srr_pkg::S_INSERT;
                end
            end

            srr_pkg::S_INSERT:
            begin
                ram_we     = 1'b1;
                ram_waddr  = phys(head_reg, pos_reg);
                ram_wdata  = seg_reg;
                count_next = count_reg + 1'b1;
                state_next = srr_pkg::S_DELIV_RD;
            end

            srr_pkg::S_DELIV_RD:
            begin
                ram_raddr = head_reg;
                if (count_reg == '0)
                begin
                    state_next = srr_pkg::S_ACK;
                end
                else
                begin
                    state_next = srr_pkg::S_DELIV_CHK;
                end
            end

            srr_pkg::S_DELIV_CHK:
            begin
                // prefetch the entry behind the head
                ram_raddr = phys(head_reg, CW'(1));
                if (rd_entry.seq_number == expect_reg)
                begin
                    emit.valid             = 1'b1;
                    emit.result.kind       = srr_pkg::KIND_DELIVER;
                    emit.result.out_tag    = rd_entry.buffer_tag;
                    emit.result.out_length = rd_entry.payload_length;
                    emit.result.ack_number = advanced;
                    emit.result.fin_seen   = rd_entry.fin_mark;
                    emit.result.status     = status_reg;
                    emit.result.last       = 1'b0;
                    expect_next = advanced;
                    fin_next    = fin_reg | rd_entry.fin_mark;
                    head_next   = phys(head_reg, CW'(1));
                    count_next  = count_reg - 1'b1;
                    if (count_reg == CW'(1))
                    begin
                        state_next = srr_pkg::S_ACK;
                    end
                end
                else
                begin
                    state_next = srr_pkg::S_ACK;
                end
            end

            srr_pkg::S_ACK:
            begin
                emit.valid             = 1'b1;
                emit.result.kind       = srr_pkg::KIND_ACK;
                emit.result.out_tag    = '0;
                emit.result.out_length = '0;
                emit.result.ack_number = expect_reg;
                emit.result.fin_seen   = fin_reg;
                emit.result.status     = status_reg;
                emit.result.last       = 1'b1;
                state_next             = srr_pkg::S_IDLE;
            end

            default:
            begin
                state_next = srr_pkg::S_IDLE;
            end
        endcase

        if (cfg.load_seq)
        begin
            expect_next = cfg.seq_value;
        end
    end

    `SRR_ASSERT_HOLDS(a_count_bound, clk, rst_n, 1'b1, count_reg <= N_CW,
        "held count exceeds window")
    `SRR_ASSERT_HOLDS(a_insert_room, clk, rst_n, state_reg == srr_pkg::S_INSERT,
        count_reg < N_CW, "insert into full window")
    `SRR_ASSERT_HOLDS(a_deliver_held, clk, rst_n,
        emit.valid && emit.result.kind == srr_pkg::KIND_DELIVER,
        count_reg != '0, "delivery from empty window")
    `SRR_ASSERT_NEXT(a_ack_ends, clk, rst_n, state_reg == srr_pkg::S_ACK,
        state_reg == srr_pkg::S_IDLE && !emit.valid, "ack not followed by idle")

endmodule

// ===== sv/segment_reorder_receiver.sv =====
// ----------------------------------------------------------------------------
// Segment reorder receiver
// Sorted reassembly of received segments with in-order delivery and a
// cumulative acknowledgement per segment.
// ----------------------------------------------------------------------------
// A segment is taken when start is high and busy is low. The block then stays
// busy while one sequencer walks the segment store, one entry per cycle over a
// single-port-read RAM: it takes the segment, searches past the held entries,
// moves the entries behind the insert point one slot up when there are any,
// inserts, reads the head and delivers each in-order segment (checking also a
// head that does not match), then gives the acknowledgement; an older,
// duplicate or full segment goes straight to delivery. Each delivery and
// the final acknowledgement appear for exactly one cycle on result with
// result_valid; the receiver cannot stall them, so results must be captured
// when shown.
// ----------------------------------------------------------------------------
module segment_reorder_receiver #(
    parameter int WINDOW_SLOTS = srr_pkg::WINDOW_SLOTS_DEFAULT
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             start,
    output logic                             busy,
    input  srr_pkg::segment_t                segment,
    output logic                             result_valid,
    output srr_pkg::result_t                 result,
    input  logic                             cfg_we,
    input  logic [srr_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [srr_pkg::CFG_DATA_W-1:0]   cfg_data
);

    logic             valid_reg, valid_next;
    srr_pkg::result_t result_reg, result_next;
    logic [7:0]       header_reg, header_next;
    srr_pkg::cfg_t    cfg;
    srr_pkg::emit_t   emit;

    always_comb
    begin
        header_next = header_reg;
        if (cfg_we && cfg_index == srr_pkg::CFG_HEADER_BYTES)
        begin
            header_next = cfg_data[7:0];
        end
        cfg.header_bytes = header_reg;
        cfg.load_seq     = cfg_we && (cfg_index == srr_pkg::CFG_INITIAL_SEQUENCE);
        cfg.seq_value    = cfg_data[31:0];
        valid_next       = emit.valid;
        result_next      = emit.result;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg  <= 1'b0;
            header_reg <= srr_pkg::HEADER_BYTES_RESET;
        end
        else
        begin
            valid_reg  <= valid_next;
            header_reg <= header_next;
        end
    end

    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
    end

    srr_core #(
        .WINDOW_SLOTS (WINDOW_SLOTS)
    ) u_core (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .segment (segment),
        .cfg     (cfg),
        .busy    (busy),
        .emit    (emit)
    );

    assign result_valid = valid_reg;
    assign result       = result_reg;

endmodule

// ===== test/segment_reorder_receiver_test.sv =====
// ----------------------------------------------------------------------------
// Segment reorder receiver testbench
// Drives segment descriptors and register writes into the receiver and checks
// every delivery and acknowledgement against a reassembly predictor kept in
// step with the accepted transactions. A directed table covers field extremes,
// every drop status, sequence wrap, a full window and a seventeen-result
// drain. Random phases then send shuffled in-order chains with noise mixed in.
// ----------------------------------------------------------------------------
module segment_reorder_receiver_test;
    timeunit 1ns;
    timeprecision 1ps;

    import srr_pkg::*;

    localparam int SLOTS        = 16;
    localparam int LOG_LIMIT    = 10;
    localparam int STALL_LIMIT  = 1000;
    localparam int SETTLE_TIME  = 64;
    localparam int RANDOM_ITEMS = 80;
    localparam int MAX_GAP      = 17;

    typedef struct {
        bit                     is_write;
        logic [CFG_INDEX_W-1:0] reg_index;
        logic [31:0]            reg_value;
        segment_t               seg;
        bit                     typed;
        status_t                want_status;
        logic [31:0]            want_ack;
    } plan_row_t;

    logic                   clk;
    logic                   rst_n;
    logic                   start;
    logic                   busy;
    segment_t               segment;
    logic                   result_valid;
    result_t                result;
    logic                   cfg_we;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;

    // reassembly state of the predictor
    logic [31:0] win_seq [SLOTS];
    logic [15:0] win_len [SLOTS];
    logic        win_fin [SLOTS];
    logic [7:0]  win_tag [SLOTS];
    int          win_count;
    logic [31:0] next_seq;
    logic [7:0]  hdr_bytes;

    result_t     awaited_results [$];
    plan_row_t   plan [$];
    int          errors;
    int          stall_cycles;
    int          items_sent;
    bit          busy_q;
    bit          burst;
    bit          hand_check;
    status_t     hand_status;
    logic [31:0] hand_ack;

    segment_reorder_receiver #(
        .WINDOW_SLOTS (SLOTS)
    ) u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .segment      (segment),
        .result_valid (result_valid),
        .result       (result),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    function automatic void report_error(input string msg);
        errors++;
        if (errors <= LOG_LIMIT)
        begin
            $display("%s", msg);
        end
    endfunction

    function automatic string describe_result(input result_t r);
        return $sformatf("kind=%0d tag=%0d len=%0d ack=%0d fin=%0d status=%0d last=%0d",
                         r.kind, r.out_tag, r.out_length, r.ack_number, r.fin_seen,
                         r.status, r.last);
    endfunction

    function automatic void reassemble_segment(input segment_t s);
        status_t st;
        int      pos;
        int      i;
        logic    fin_any;
        result_t r;
        st      = STATUS_ACCEPTED;
        pos     = 0;
        fin_any = 1'b0;
        if (s.seq_number < next_seq)
        begin
            st = STATUS_OLDER;
        end
        else
        begin
            while (pos < win_count && win_seq[pos] < s.seq_number)
                pos++;
            if (pos < win_count && win_seq[pos] == s.seq_number)
                st = STATUS_DUPLICATE;
            else if (win_count >= SLOTS)
                st = STATUS_FULL;
        end
        if (st == STATUS_ACCEPTED)
        begin
            for (i = win_count; i > pos; i--)
            begin
                win_seq[i] = win_seq[i-1];
                win_len[i] = win_len[i-1];
                win_fin[i] = win_fin[i-1];
                win_tag[i] = win_tag[i-1];
            end
            win_seq[pos] = s.seq_number;
            win_len[pos] = s.payload_length;
            win_fin[pos] = s.fin_mark;
            win_tag[pos] = s.buffer_tag;
            win_count++;
        end
        while (win_count > 0 && win_seq[0] == next_seq)
        begin
            next_seq     = next_seq + 32'(win_len[0]) + 32'(hdr_bytes);
            fin_any      = fin_any | win_fin[0];
            r.kind       = KIND_DELIVER;
            r.out_tag    = win_tag[0];
            r.out_length = win_len[0];
            r.ack_number = next_seq;
            r.fin_seen   = win_fin[0];
            r.status     = st;
            r.last       = 1'b0;
            awaited_results.push_back(r);
            for (i = 1; i < win_count; i++)
            begin
                win_seq[i-1] = win_seq[i];
                win_len[i-1] = win_len[i];
                win_fin[i-1] = win_fin[i];
                win_tag[i-1] = win_tag[i];
            end
            win_count--;
        end
        r.kind       = KIND_ACK;
        r.out_tag    = 8'd0;
        r.out_length = 16'd0;
        r.ack_number = next_seq;
        r.fin_seen   = fin_any;
        r.status     = st;
        r.last       = 1'b1;
        awaited_results.push_back(r);
    endfunction

    // sample at the rising edge: check results, track writes, predict accepted segments
    always @(posedge clk)
    begin
        result_t want;
        int      base;
        int      i;
        if (rst_n)
        begin
            busy_q = busy;
            if (result_valid)
            begin
                if (awaited_results.size() == 0)
                begin
                    report_error($sformatf("unexpected result: %s", describe_result(result)));
                end
                else
                begin
                    want = awaited_results.pop_front();
                    if (result.kind !== want.kind || result.out_tag !== want.out_tag ||
                        result.out_length !== want.out_length ||
                        result.ack_number !== want.ack_number ||
                        result.fin_seen !== want.fin_seen || result.status !== want.status ||
                        result.last !== want.last)
                    begin
                        report_error($sformatf("result mismatch: expected %s, got %s",
                                               describe_result(want), describe_result(result)));
                    end
                end
            end
            if (cfg_we)
            begin
                if (cfg_index == CFG_HEADER_BYTES)
                    hdr_bytes = cfg_data[7:0];
                else if (cfg_index == CFG_INITIAL_SEQUENCE)
                    next_seq = cfg_data;
            end
            if (start && !busy)
            begin
                base = awaited_results.size();
                reassemble_segment(segment);
                if (hand_check)
                begin
                    for (i = base; i < awaited_results.size(); i++)
                    begin
                        want        = awaited_results[i];
                        want.status = hand_status;
                        if (i == awaited_results.size() - 1)
                            want.ack_number = hand_ack;
                        awaited_results[i] = want;
                    end
                end
            end
            if (result_valid || (start && !busy))
            begin
                stall_cycles = 0;
            end
            else
            begin
                stall_cycles++;
                if (stall_cycles >= STALL_LIMIT)
                begin
                    $display("[segment_reorder_receiver] ERROR");
                    $finish;
                end
            end
        end
    end

    function automatic int unsigned draw_gap();
        return burst ? 0 : $urandom_range(0, MAX_GAP);
    endfunction

    function automatic segment_t random_segment();
        segment_t s;
        s.seq_number     = $urandom;
        s.payload_length = 16'($urandom);
        s.fin_mark       = 1'($urandom);
        s.buffer_tag     = 8'($urandom);
        return s;
    endfunction

    function automatic void plan_segment(input logic [31:0] seq, input logic [15:0] len,
                                         input logic fin, input logic [7:0] tag,
                                         input bit typed, input status_t st,
                                         input logic [31:0] ack);
        plan_row_t row;
        row.is_write               = 1'b0;
        row.reg_index              = '0;
        row.reg_value              = '0;
        row.seg.seq_number         = seq;
        row.seg.payload_length     = len;
        row.seg.fin_mark           = fin;
        row.seg.buffer_tag         = tag;
        row.typed                  = typed;
        row.want_status            = st;
        row.want_ack               = ack;
        plan.push_back(row);
    endfunction

    function automatic void plan_write(input logic [CFG_INDEX_W-1:0] idx,
                                       input logic [31:0] value);
        plan_row_t row;
        row.is_write    = 1'b1;
        row.reg_index   = idx;
        row.reg_value   = value;
        row.seg         = '0;
        row.typed       = 1'b0;
        row.want_status = STATUS_ACCEPTED;
        row.want_ack    = '0;
        plan.push_back(row);
    endfunction

    // called at a falling edge; returns at the falling edge after acceptance
    task automatic send_segment(input segment_t s, input int unsigned gap);
        if (gap != 0)
        begin
            start <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        segment <= s;
        start   <= 1'b1;
        do
            @(posedge clk);
        while (busy !== 1'b0);
        @(negedge clk);
    endtask

    task automatic wait_idle();
        start <= 1'b0;
        @(negedge clk);
        while (awaited_results.size() != 0 || busy_q)
            @(negedge clk);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [31:0] value);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(negedge clk);
        cfg_we <= 1'b0;
        @(negedge clk);
    endtask

    // empty the window: point the expected number at the head and poke it with a duplicate
    task automatic drain_window();
        segment_t s;
        while (win_count != 0)
        begin
            wait_idle();
            write_reg(CFG_INITIAL_SEQUENCE, win_seq[0]);
            s            = random_segment();
            s.seq_number = win_seq[0];
            send_segment(s, draw_gap());
            items_sent++;
        end
    endtask

    initial
    begin
        plan_row_t   row;
        segment_t    s;
        logic [31:0] link_seq [SLOTS];
        logic [15:0] link_len [SLOTS];
        logic        link_fin [SLOTS];
        int          order [SLOTS];
        int          n;
        int          k;
        int          j;
        int          tmp;
        logic [7:0]  hdr;
        logic [31:0] base_seq;

        start        = 1'b0;
        segment      = '0;
        cfg_we       = 1'b0;
        cfg_index    = '0;
        cfg_data     = '0;
        rst_n        = 1'b0;
        hand_check   = 1'b0;
        hand_status  = STATUS_ACCEPTED;
        hand_ack     = '0;
        burst        = 1'b0;
        busy_q       = 1'b0;
        errors       = 0;
        stall_cycles = 0;
        items_sent   = 0;
        win_count    = 0;
        next_seq     = INITIAL_SEQUENCE_RESET;
        hdr_bytes    = HEADER_BYTES_RESET;

        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed table
        plan_segment(32'd1, 16'd0, 1'b0, 8'd0, 1'b1, STATUS_ACCEPTED, 32'd17);
        plan_segment(32'd0, 16'hFFFF, 1'b1, 8'hFF, 1'b1, STATUS_OLDER, 32'd17);
        plan_segment(32'd17, 16'hFFFF, 1'b1, 8'hFF, 1'b1, STATUS_ACCEPTED, 32'd65568);
        plan_segment(32'hFFFF_FFFF, 16'd100, 1'b0, 8'd1, 1'b1, STATUS_ACCEPTED, 32'd65568);
        plan_segment(32'hFFFF_FFFF, 16'd7, 1'b1, 8'd9, 1'b1, STATUS_DUPLICATE, 32'd65568);
        plan_write(CFG_HEADER_BYTES, 32'd0);
        plan_write(CFG_INITIAL_SEQUENCE, 32'hFFFF_FFFF);
        // older segment still triggers delivery of the held head; expected number wraps
        plan_segment(32'hFFFF_FFFE, 16'd0, 1'b0, 8'd0, 1'b1, STATUS_OLDER, 32'd99);
        plan_write(CFG_HEADER_BYTES, 32'd255);
        plan_write(CFG_INITIAL_SEQUENCE, 32'd0);
        link_seq[0] = 32'd500;
        for (k = 0; k < SLOTS - 1; k++)
            link_seq[k+1] = link_seq[k] + 32'(16 * k + 1) + 32'd255;
        for (k = SLOTS - 1; k >= 0; k--)
            plan_segment(link_seq[k], 16'(16 * k + 1), 1'(k == SLOTS - 1), 8'(k + 32),
                         1'b0, STATUS_ACCEPTED, 32'd0);
        plan_segment(32'h8000_0000, 16'd3, 1'b0, 8'd77, 1'b1, STATUS_FULL, 32'd0);
        plan_segment(link_seq[7], 16'd3, 1'b0, 8'd78, 1'b1, STATUS_DUPLICATE, 32'd0);
        plan_write(CFG_INITIAL_SEQUENCE, 32'd500);
        plan_segment(32'd500, 16'd1, 1'b0, 8'd79, 1'b0, STATUS_DUPLICATE, 32'd0);

        foreach (plan[i])
        begin
            row = plan[i];
            if (row.is_write)
            begin
                wait_idle();
                write_reg(row.reg_index, row.reg_value);
            end
            else
            begin
                hand_check  = row.typed;
                hand_status = row.want_status;
                hand_ack    = row.want_ack;
                send_segment(row.seg, $urandom_range(0, MAX_GAP));
                hand_check  = 1'b0;
            end
        end

        // random phases: shuffled in-order chains with noise
        items_sent = 0;
        while (items_sent < RANDOM_ITEMS)
        begin
            wait_idle();
            drain_window();
            wait_idle();
            burst = ($urandom_range(0, 3) == 0);
            case ($urandom_range(0, 3))
                0:       hdr = 8'd0;
                1:       hdr = 8'hFF;
                default: hdr = 8'($urandom);
            endcase
            write_reg(CFG_HEADER_BYTES, {24'd0, hdr});
            case ($urandom_range(0, 7))
                0:       base_seq = 32'hFFFF_FFFF - $urandom_range(0, 3000);
                1:       base_seq = 32'd0;
                default: base_seq = $urandom;
            endcase
            write_reg(CFG_INITIAL_SEQUENCE, base_seq);

            n = $urandom_range(1, 14);
            link_seq[0] = base_seq;
            for (k = 0; k < n; k++)
            begin
                link_len[k] = ($urandom_range(0, 9) == 0) ? 16'($urandom)
                                                          : 16'($urandom_range(0, 1500));
                link_fin[k] = (k == n - 1) ? 1'($urandom) : ($urandom_range(0, 15) == 0);
                if (k + 1 < SLOTS)
                    link_seq[k+1] = link_seq[k] + 32'(link_len[k]) + 32'(hdr);
                order[k] = k;
            end
            for (k = n - 1; k > 0; k--)
            begin
                j        = $urandom_range(0, k);
                tmp      = order[k];
                order[k] = order[j];
                order[j] = tmp;
            end

            for (k = 0; k < n; k++)
            begin
                if ($urandom_range(0, 4) == 0)
                begin
                    s = random_segment();
                    j = $urandom_range(0, n - 1);
                    case ($urandom_range(0, 4))
                        0, 1: s.seq_number = link_seq[j];
                        2:    s.seq_number = (next_seq == 0) ? 32'd0
                                                             : $urandom_range(0, next_seq - 1);
                        3:    s.seq_number = link_seq[j] + 32'd1;
                        default: ;
                    endcase
                    send_segment(s, draw_gap());
                    items_sent++;
                end
                s.seq_number     = link_seq[order[k]];
                s.payload_length = link_len[order[k]];
                s.fin_mark       = link_fin[order[k]];
                s.buffer_tag     = 8'($urandom);
                send_segment(s, draw_gap());
                items_sent++;
                if ($urandom_range(0, 19) == 0)
                    wait_idle();
            end
        end

        wait_idle();
        repeat (SETTLE_TIME) @(posedge clk);
        if (awaited_results.size() != 0)
            report_error($sformatf("%0d results never arrived", awaited_results.size()));
        if (errors == 0)
            $display("[segment_reorder_receiver] OK");
        else
            $display("[segment_reorder_receiver] ERROR");
        $finish;
    end

endmodule

// ===== segment_reorder_receiver.f =====
+incdir+sv
sv/srr_pkg.sv
sv/srr_ram.sv
sv/srr_core.sv
sv/segment_reorder_receiver.sv
test/segment_reorder_receiver_test.sv
